// ===== sv/wuf_pkg.sv =====
package wuf_pkg;

    localparam int FIELD_W = 10;
    localparam int FIELD_MAX = 1023;
    localparam int MAX_ELEMENTS_DEF = 1023;
    localparam logic [FIELD_W-1:0] NUM_ELEMENTS_RST = 10'd1023;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_SIZE_A,
        S_SIZE_B,
        S_LINK,
        S_CLEAR,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SWEEP,
        OP_LOAD,
        OP_WALK_A,
        OP_WALK_B,
        OP_SIZE_A,
        OP_SIZE_B,
        OP_LINK,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic at_root;
        logic sweep_last;
        logic new_kind;
        logic new_err;
        logic out_free;
    } status_t;

endpackage

// ===== sv/wuf_datapath.sv =====
module wuf_datapath
    import wuf_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               kind,
    input  logic [FIELD_W-1:0] first_item,
    input  logic [FIELD_W-1:0] second_item,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               already_connected,
    output logic               index_error,
    output logic [FIELD_W-1:0] group_size,
    output logic [FIELD_W-1:0] largest_size,
    output logic [FIELD_W-1:0] largest_leader,
    input  cmd_t               cmd,
    output status_t            status
);

    // only indices up to the field range can ever be reached
    localparam int CAP = (MAX_ELEMENTS < FIELD_MAX) ? MAX_ELEMENTS : FIELD_MAX;
    localparam int DEPTH = CAP + 1;
    localparam int AW = $clog2(DEPTH);
    localparam logic [FIELD_W-1:0] LIMIT_CAP = FIELD_W'(CAP);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAP);

    logic [AW-1:0]      parent_mem [DEPTH];
    logic [FIELD_W-1:0] size_mem [DEPTH];

    logic               par_we;
    logic [AW-1:0]      par_waddr;
    logic [AW-1:0]      par_wdata;
    logic [AW-1:0]      par_raddr;
    logic [AW-1:0]      par_rdata_reg;
    logic               size_we;
    logic [AW-1:0]      size_waddr;
    logic [FIELD_W-1:0] size_wdata;
    logic [AW-1:0]      size_raddr;
    logic [FIELD_W-1:0] size_rdata_reg;

    logic [FIELD_W-1:0] num_elements_reg;
    logic [AW-1:0]      sweep_cnt_reg, sweep_cnt_next;
    logic [FIELD_W-1:0] best_size_reg, best_size_next;
    logic [AW-1:0]      best_leader_reg, best_leader_next;
    logic               out_valid_reg, out_valid_next;

    logic [AW-1:0]      node_reg, node_next;
    logic [AW-1:0]      b_reg, b_next;
    logic [AW-1:0]      ra_reg, ra_next;
    logic [AW-1:0]      rb_reg, rb_next;
    logic [FIELD_W-1:0] sa_reg, sa_next;
    logic [FIELD_W-1:0] sb_reg, sb_next;
    logic [FIELD_W-1:0] grp_reg, grp_next;
    logic               joined_reg, joined_next;
    logic               err_reg, err_next;

    logic               out_joined_reg;
    logic               out_err_reg;
    logic [FIELD_W-1:0] out_grp_reg;
    logic [FIELD_W-1:0] out_best_size_reg;
    logic [FIELD_W-1:0] out_best_leader_reg;

    logic [FIELD_W-1:0] limit;
    logic               new_err;
    logic               at_root;
    logic               same_root;
    logic [FIELD_W:0]   sum_wide;
    logic [FIELD_W-1:0] link_sum;
    logic               sa_less;
    logic [AW-1:0]      top_root;
    logic [AW-1:0]      low_root;
    logic               better;
    logic               out_free;
    logic               out_load;

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_waddr] <= par_wdata;
        end
        par_rdata_reg <= parent_mem[par_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rdata_reg <= size_mem[size_raddr];
    end

    assign limit = (num_elements_reg > LIMIT_CAP) ? LIMIT_CAP : num_elements_reg;
    assign new_err = (first_item == '0) || (second_item == '0) ||
                     (first_item > limit) || (second_item > limit);
    assign at_root = (par_rdata_reg == node_reg);
    assign same_root = (ra_reg == rb_reg);
    assign sum_wide = {1'b0, sa_reg} + {1'b0, sb_reg};
    assign link_sum = sum_wide[FIELD_W-1:0];
    // the smaller tree goes under the larger, first root wins on a tie
    assign sa_less = (sa_reg < sb_reg);
    assign top_root = sa_less ? rb_reg : ra_reg;
    assign low_root = sa_less ? ra_reg : rb_reg;
    assign better = (link_sum > best_size_reg) ||
                    ((link_sum == best_size_reg) && (top_root < best_leader_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (cmd.op == OP_EMIT) && out_free;

    always_comb
    begin
        par_we = 1'b0;
        par_waddr = low_root;
        par_wdata = top_root;
        par_raddr = node_reg;
        size_we = 1'b0;
        size_waddr = top_root;
        size_wdata = link_sum;
        size_raddr = ra_reg;
        sweep_cnt_next = sweep_cnt_reg;
        best_size_next = best_size_reg;
        best_leader_next = best_leader_reg;
        node_next = node_reg;
        b_next = b_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        sa_next = sa_reg;
        sb_next = sb_reg;
        grp_next = grp_reg;
        joined_next = joined_reg;
        err_next = err_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_SWEEP:
            begin
                par_we = 1'b1;
                par_waddr = sweep_cnt_reg;
                par_wdata = sweep_cnt_reg;
                size_we = 1'b1;
                size_waddr = sweep_cnt_reg;
                size_wdata = FIELD_W'(1);
                sweep_cnt_next = (sweep_cnt_reg == LAST_ADDR) ? '0 : sweep_cnt_reg + 1'b1;
                best_size_next = FIELD_W'(1);
                best_leader_next = AW'(1);
            end
            OP_LOAD:
            begin
                node_next = first_item[AW-1:0];
                b_next = second_item[AW-1:0];
                par_raddr = first_item[AW-1:0];
                err_next = new_err && !kind;
                joined_next = 1'b0;
                grp_next = kind ? FIELD_W'(1) : '0;
            end
            OP_WALK_A:
            begin
                if (at_root)
                begin
                    ra_next = node_reg;
                    node_next = b_reg;
                    par_raddr = b_reg;
                end
                else
                begin
                    node_next = par_rdata_reg;
                    par_raddr = par_rdata_reg;
                end
            end
            OP_WALK_B:
            begin
                if (at_root)
                begin
                    rb_next = node_reg;
                    size_raddr = ra_reg;
                end
                else
                begin
                    node_next = par_rdata_reg;
                    par_raddr = par_rdata_reg;
                end
            end
            OP_SIZE_A:
            begin
                sa_next = size_rdata_reg;
                size_raddr = rb_reg;
            end
            OP_SIZE_B:
            begin
                sb_next = size_rdata_reg;
            end
            OP_LINK:
            begin
                if (same_root)
                begin
                    joined_next = 1'b1;
                    grp_next = sa_reg;
                end
                else
                begin
                    par_we = 1'b1;
                    size_we = 1'b1;
                    grp_next = link_sum;
                    if (better)
                    begin
                        best_size_next = link_sum;
                        best_leader_next = top_root;
                    end
                end
            end
            OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_elements_reg <= NUM_ELEMENTS_RST;
            sweep_cnt_reg <= '0;
            best_size_reg <= FIELD_W'(1);
            best_leader_reg <= AW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_elements_reg <= cfg_data;
            end
            sweep_cnt_reg <= sweep_cnt_next;
            best_size_reg <= best_size_next;
            best_leader_reg <= best_leader_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        b_reg <= b_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        sa_reg <= sa_next;
        sb_reg <= sb_next;
        grp_reg <= grp_next;
        joined_reg <= joined_next;
        err_reg <= err_next;
        if (out_load)
        begin
            out_joined_reg <= joined_reg;
            out_err_reg <= err_reg;
            out_grp_reg <= grp_reg;
            out_best_size_reg <= best_size_reg;
            out_best_leader_reg <= FIELD_W'(best_leader_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign already_connected = out_joined_reg;
    assign index_error = out_err_reg;
    assign group_size = out_grp_reg;
    assign largest_size = out_best_size_reg;
    assign largest_leader = out_best_leader_reg;

    assign status.at_root = at_root;
    assign status.sweep_last = (sweep_cnt_reg == LAST_ADDR);
    assign status.new_kind = kind;
    assign status.new_err = new_err;
    assign status.out_free = out_free;

    // element zero is never linked, so a walk never visits it
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WALK_A || cmd.op == OP_WALK_B) |-> (node_reg != '0))
        else $error("root walk reached element zero");

    // the largest record only shrinks on a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_SWEEP) |=> (best_size_reg >= $past(best_size_reg)))
        else $error("largest size went down without a clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LINK && !same_root) |=> (grp_reg >= FIELD_W'(2)))
        else $error("merged group smaller than two");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == OP_EMIT))
        else $error("result beat raised outside emit");

endmodule

// ===== sv/wuf_controller.sv =====
module wuf_controller
    import wuf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        in_stall = 1'b1;
        unique case (state_reg)
            S_INIT:
            begin
                // table sweep after reset
                cmd.op = OP_SWEEP;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (status.new_kind)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (status.new_err)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_WALK_A;
                    end
                end
            end
            S_WALK_A:
            begin
                cmd.op = OP_WALK_A;
                if (status.at_root)
                begin
                    state_next = S_WALK_B;
                end
            end
            S_WALK_B:
            begin
                cmd.op = OP_WALK_B;
                if (status.at_root)
                begin
                    state_next = S_SIZE_A;
                end
            end
            S_SIZE_A:
            begin
                cmd.op = OP_SIZE_A;
                state_next = S_SIZE_B;
            end
            S_SIZE_B:
            begin
                cmd.op = OP_SIZE_B;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                cmd.op = OP_LINK;
                state_next = S_EMIT;
            end
            S_CLEAR:
            begin
                cmd.op = OP_SWEEP;
                if (status.sweep_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/weighted_union_find.sv =====
// connect: the root walks follow both elements up their trees hop by hop, d1 and d2 hops for
// tree depths d1 and d2 (at most 9 each at 1023 elements); the two walks share in turn
// the single read port of the parent memory, walk A first and then walk B
// out-of-range connect: no walk, straight to the result; clear: a table sweep
// one item at a time; a waiting result does not block the next accept
// after reset a sweep over entries 0 to MAX_ELEMENTS (capped at 1023) initializes the tables
module weighted_union_find
    import wuf_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [FIELD_W-1:0] first_item,
    input  logic [FIELD_W-1:0] second_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               already_connected,
    output logic               index_error,
    output logic [FIELD_W-1:0] group_size,
    output logic [FIELD_W-1:0] largest_size,
    output logic [FIELD_W-1:0] largest_leader
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    wuf_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wuf_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .kind              (kind),
        .first_item        (first_item),
        .second_item       (second_item),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .already_connected (already_connected),
        .index_error       (index_error),
        .group_size        (group_size),
        .largest_size      (largest_size),
        .largest_leader    (largest_leader),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

// ===== verif/tb_weighted_union_find.sv =====
`timescale 1ns / 1ps

module tb_weighted_union_find;
    import wuf_pkg::*;

    localparam int MAX_EL = MAX_ELEMENTS_DEF;
    localparam bit KIND_CONNECT = 1'b0;
    localparam bit KIND_CLEAR = 1'b1;
    localparam int N_PHASES = 8;
    localparam int HOLD_AT = 700;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic               joined;
        logic               bad_index;
        logic [FIELD_W-1:0] grp;
        logic [FIELD_W-1:0] top_size;
        logic [FIELD_W-1:0] top_leader;
    } outcome_t;

    typedef struct {
        bit       set_count;
        bit       kind;
        int       a;
        int       b;
        bit       typed;
        outcome_t want;
    } step_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [FIELD_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = 1'b0;
    logic [FIELD_W-1:0] first_item = '0;
    logic [FIELD_W-1:0] second_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               already_connected;
    logic               index_error;
    logic [FIELD_W-1:0] group_size;
    logic [FIELD_W-1:0] largest_size;
    logic [FIELD_W-1:0] largest_leader;

    weighted_union_find #(
        .MAX_ELEMENTS(MAX_EL)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .first_item       (first_item),
        .second_item      (second_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .already_connected(already_connected),
        .index_error      (index_error),
        .group_size       (group_size),
        .largest_size     (largest_size),
        .largest_leader   (largest_leader)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // disjoint-set shadow of the block
    logic [FIELD_W-1:0] parent_of [0:MAX_EL];
    int unsigned        size_of [0:MAX_EL];
    int unsigned        best_size;
    int unsigned        best_leader;
    int unsigned        elem_count;

    outcome_t  outcome_q [$];
    step_row_t steps [$];

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int strays = 0;
    int merges = 0;
    int joined_hits = 0;
    int index_errs = 0;
    int clears = 0;
    int count_writes = 0;
    int peak_size = 1;
    int quiet = 0;

    function automatic void make_singletons();
        for (int e = 0; e <= MAX_EL; e++)
        begin
            parent_of[e] = e[FIELD_W-1:0];
            size_of[e] = 1;
        end
        best_size = 1;
        best_leader = 1;
    endfunction

    function automatic int unsigned find_root(int unsigned node);
        int unsigned hops;
        hops = 0;
        while (hops <= MAX_EL && parent_of[node] != node)
        begin
            node = parent_of[node];
            hops++;
        end
        return node;
    endfunction

    function automatic outcome_t pack_outcome(bit j, bit e, int unsigned g);
        outcome_t o;
        o.joined = j;
        o.bad_index = e;
        o.grp = g[FIELD_W-1:0];
        o.top_size = best_size[FIELD_W-1:0];
        o.top_leader = best_leader[FIELD_W-1:0];
        return o;
    endfunction

    function automatic outcome_t want_of(bit j, bit e, int g, int s, int l);
        outcome_t o;
        o.joined = j;
        o.bad_index = e;
        o.grp = g[FIELD_W-1:0];
        o.top_size = s[FIELD_W-1:0];
        o.top_leader = l[FIELD_W-1:0];
        return o;
    endfunction

    function automatic outcome_t join_or_clear(bit k, int unsigned a, int unsigned b);
        int unsigned lim;
        int unsigned ra;
        int unsigned rb;
        int unsigned top;
        int unsigned grp;
        if (k == KIND_CLEAR)
        begin
            make_singletons();
            clears++;
            return pack_outcome(1'b0, 1'b0, 1);
        end
        lim = (elem_count > MAX_EL) ? MAX_EL : elem_count;
        if (a == 0 || b == 0 || a > lim || b > lim)
        begin
            index_errs++;
            return pack_outcome(1'b0, 1'b1, 0);
        end
        ra = find_root(a);
        rb = find_root(b);
        if (ra == rb)
        begin
            joined_hits++;
            return pack_outcome(1'b1, 1'b0, size_of[ra]);
        end
        // smaller tree goes under the larger, first root wins a tie
        if (size_of[ra] < size_of[rb])
        begin
            parent_of[ra] = rb[FIELD_W-1:0];
            size_of[rb] = (size_of[rb] + size_of[ra]) & 16'hFFFF;
            top = rb;
        end
        else
        begin
            parent_of[rb] = ra[FIELD_W-1:0];
            size_of[ra] = (size_of[ra] + size_of[rb]) & 16'hFFFF;
            top = ra;
        end
        grp = size_of[top];
        if (grp > best_size || (grp == best_size && top < best_leader))
        begin
            best_size = grp;
            best_leader = top;
        end
        if (grp > peak_size)
            peak_size = grp;
        merges++;
        return pack_outcome(1'b0, 1'b0, grp);
    endfunction

    task automatic add_row(bit set_count, bit k, int a, int b, bit typed, outcome_t w);
        step_row_t r;
        r.set_count = set_count;
        r.kind = k;
        r.a = a;
        r.b = b;
        r.typed = typed;
        r.want = w;
        steps.push_back(r);
    endtask

    task automatic offer_item(bit k, int unsigned a, int unsigned b, bit typed, outcome_t w);
        int       gap;
        outcome_t guess;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        kind = k;
        first_item = a[FIELD_W-1:0];
        second_item = b[FIELD_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        guess = join_or_clear(k, a, b);
        outcome_q.push_back(typed ? w : guess);
        items_sent++;
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
    endtask

    // sender holds off until the block has returned every outstanding beat
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_count(int unsigned v);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v[FIELD_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        elem_count = v;
        count_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        int          phase_n [N_PHASES];
        int          phase_items [N_PHASES];
        int unsigned n;
        int unsigned a;
        int unsigned b;
        int unsigned bv;
        int          r;
        phase_n = '{1023, 2, 37, 1, 1023, 512, 0, 1023};
        phase_items = '{500, 120, 200, 60, 400, 250, 200, 170};
        make_singletons();
        elem_count = NUM_ELEMENTS_RST;

        add_row(1'b0, KIND_CONNECT, 0, 5, 1'b1, want_of(0, 1, 0, 1, 1));
        add_row(1'b0, KIND_CONNECT, 5, 0, 1'b1, want_of(0, 1, 0, 1, 1));
        add_row(1'b0, KIND_CONNECT, 1, 1, 1'b1, want_of(1, 0, 1, 1, 1));
        add_row(1'b0, KIND_CONNECT, 1023, 1022, 1'b1, want_of(0, 0, 2, 2, 1023));
        add_row(1'b0, KIND_CONNECT, 1, 2, 1'b1, want_of(0, 0, 2, 2, 1));
        add_row(1'b0, KIND_CONNECT, 2, 1, 1'b1, want_of(1, 0, 2, 2, 1));
        add_row(1'b0, KIND_CONNECT, 3, 1, 1'b1, want_of(0, 0, 3, 3, 1));
        add_row(1'b0, KIND_CONNECT, 1022, 1, 1'b1, want_of(0, 0, 5, 5, 1));
        add_row(1'b0, KIND_CONNECT, 1023, 3, 1'b1, want_of(1, 0, 5, 5, 1));
        add_row(1'b0, KIND_CONNECT, 0, 0, 1'b1, want_of(0, 1, 0, 5, 1));
        add_row(1'b0, KIND_CLEAR, 1023, 1023, 1'b1, want_of(0, 0, 1, 1, 1));
        add_row(1'b0, KIND_CONNECT, 4, 3, 1'b1, want_of(0, 0, 2, 2, 4));
        // equal sizes: first root stays, and the smaller leader takes the tie
        add_row(1'b0, KIND_CONNECT, 2, 1, 1'b1, want_of(0, 0, 2, 2, 2));
        add_row(1'b0, KIND_CONNECT, 6, 5, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 4, 6, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 8, 7, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 10, 9, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 8, 10, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 5, 9, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 7, 3, 1'b0, '0);
        add_row(1'b1, KIND_CONNECT, 1, 0, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 1, 1, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 1, 2, 1'b0, '0);
        add_row(1'b1, KIND_CONNECT, 1023, 0, 1'b0, '0);
        add_row(1'b0, KIND_CONNECT, 1023, 1, 1'b0, '0);
        add_row(1'b0, KIND_CLEAR, 0, 0, 1'b1, want_of(0, 0, 1, 1, 1));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (steps[i])
        begin
            if (steps[i].set_count)
                write_count(steps[i].a);
            else
                offer_item(steps[i].kind, steps[i].a, steps[i].b, steps[i].typed,
                           steps[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            n = (phase_n[p] == 0) ? $urandom_range(3, 1022) : phase_n[p];
            write_count(n);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (p == 4 && i == 200)
                    drain();
                r = $urandom_range(0, 999);
                if (r < 12)
                begin
                    offer_item(KIND_CLEAR, $urandom_range(0, FIELD_MAX),
                               $urandom_range(0, FIELD_MAX), 1'b0, '0);
                end
                else if (r < 80)
                begin
                    // zero or beyond the element count on one side at least
                    if (n < FIELD_MAX && $urandom_range(0, 1) == 1)
                        bv = $urandom_range(n + 1, FIELD_MAX);
                    else
                        bv = 0;
                    a = $urandom_range(0, FIELD_MAX);
                    if ($urandom_range(0, 1) == 1)
                        offer_item(KIND_CONNECT, bv, a, 1'b0, '0);
                    else
                        offer_item(KIND_CONNECT, a, bv, 1'b0, '0);
                end
                else
                begin
                    a = $urandom_range(1, n);
                    b = $urandom_range(1, n);
                    offer_item(KIND_CONNECT, a, b, 1'b0, '0);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d items and %0d register writes: %0d merges, %0d joined,",
                 items_sent, count_writes, merges, joined_hits);
        $display("%0d index errors, %0d clears, largest group %0d, %0d results checked",
                 index_errs, clears, peak_size, results_seen);
        if (mismatches == 0 && strays == 0 && outcome_q.size() == 0)
            $display("tb_weighted_union_find: PASS");
        else
            $display("tb_weighted_union_find: FAIL");
        $finish;
    end

    initial
    begin : receiver
        int       gap;
        outcome_t got;
        outcome_t want;
        forever
        begin
            @(negedge clk);
            gap = rx_burst ? 0 : $urandom_range(0, 11);
            // one long hold-off so the block backs up and stalls its input
            if (results_seen == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap != 0)
            begin
                out_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.joined = already_connected;
            got.bad_index = index_error;
            got.grp = group_size;
            got.top_size = largest_size;
            got.top_leader = largest_leader;
            results_seen++;
            if (outcome_q.size() == 0)
            begin
                strays++;
                if (strays + mismatches <= 10)
                    $display("beat %0d arrived with nothing outstanding", results_seen);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (strays + mismatches <= 10)
                        $display({"beat %0d: expected conn=%0b err=%0b grp=%0d big=%0d lead=%0d,",
                                  " got conn=%0b err=%0b grp=%0d big=%0d lead=%0d"},
                                 results_seen, want.joined, want.bad_index, want.grp,
                                 want.top_size, want.top_leader, got.joined, got.bad_index,
                                 got.grp, got.top_size, got.top_leader);
                end
            end
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("no handshake for %0d cycles", quiet);
            $display("tb_weighted_union_find: FAIL");
            $finish;
        end
    end

endmodule

// ===== files.f =====
sv/wuf_pkg.sv
sv/wuf_datapath.sv
sv/wuf_controller.sv
sv/weighted_union_find.sv
verif/tb_weighted_union_find.sv
